>>> src/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is low.
`define CFLA_ASSERT_SYNC(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("chunk allocator check failed");

// Same check, written as a cause and its consequence on the same edge.
`define CFLA_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  `CFLA_ASSERT_SYNC(name, clk, rst_n, (ante) |-> (cons))

`endif

>>> src/cfla_pkg.sv
// ----------------------------------------------------------------------------
// Chunk allocator package
// Widths, depths, request codes and status codes of the chunk free-list
// allocator, shared by the top level and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfla_pkg;

  // Pool geometry.
  localparam int POOL_DEPTH = 4096;
  localparam int PTR_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = 13;
  localparam int ADDR_W     = 28;

  // Field widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 17;
  localparam int CIDX_W   = 2;

  // Remainder unit: one dividend bit a cycle, from the top bit down.
  localparam int BIT_W = $clog2(ADDR_W);

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CIDX_W-1:0]   cidx_t;

  // Request codes.
  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_FREE    = 2'd1;
  localparam op_t OP_RESTART = 2'd2;

  // Status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Configuration register indexes.
  localparam cidx_t REG_CHUNK_SIZE  = 2'd0;
  localparam cidx_t REG_CHUNK_COUNT = 2'd1;

  // Reset values of the configuration registers.
  localparam size_t  SIZE_RESET  = 17'd2048;
  localparam count_t COUNT_RESET = 13'd4096;

endpackage

`default_nettype wire

>>> src/chunk_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Chunk free-list allocator
// Last-in first-out stack of buffer chunk addresses with allocate, free and
// restart requests, built around one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  in       in_valid / in_stall  in_operation, in_free_address
//  out      out_valid/ out_stall out_chunk_address, out_status, out_free_count
//  cfg      cfg_valid/ cfg_ready cfg_index, cfg_wdata
//
//  One request at a time; in_stall is high while a request is in work.
//  Allocate passes through accept, pool memory read and result, the read
//  going through the registered read port; from an empty pool it goes from
//  accept straight to result. Free finds the remainder by the chunk size
//  one address bit a cycle on the shared adder, then aligns and pushes.
//  Restart writes one chunk per cycle; an unused code goes straight to result.
//  No clearing pass after reset: the pool count is zero and only written
//  entries are ever read. A stalled result holds the block in its last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chunk_free_list_allocator
  import cfla_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  // Request channel
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [OP_W-1:0]     in_operation,
  input  wire  [ADDR_W-1:0]   in_free_address,
  // Result channel
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [ADDR_W-1:0]   out_chunk_address,
  output logic [STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]    out_free_count,
  // Configuration channel
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [CIDX_W-1:0]   cfg_index,
  input  wire  [SIZE_W-1:0]   cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_ALIGN  = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]  state_r, state_nxt;
  addr_t       addr_r, addr_nxt;
  size_t       rem_r, rem_nxt;
  logic [BIT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  addr_t       acc_r, acc_nxt;
  count_t      idx_r, idx_nxt;
  count_t      fill_n_r, fill_n_nxt;
  count_t      count_r, count_nxt;
  addr_t       res_addr_r, res_addr_nxt;
  status_t     res_status_r, res_status_nxt;
  size_t       size_r, size_nxt;
  count_t      ccount_r, ccount_nxt;
  logic        out_valid_r, out_valid_nxt;
  addr_t       out_addr_r, out_addr_nxt;
  status_t     out_status_r, out_status_nxt;
  count_t      out_count_r, out_count_nxt;

  // Pool memory: one write and one registered read port.
  addr_t             pool_mem [POOL_DEPTH];
  addr_t             rd_data_r;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  addr_t             mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;

  // Shared adder.
  addr_t             alu_a;
  addr_t             alu_b;
  logic              alu_sub;
  logic [ADDR_W:0]   alu_res;

  logic              in_fire;
  logic              out_free;
  size_t             sz_eff;
  logic [SIZE_W:0]   div_shift;
  count_t            fill_target;
  count_t            count_dec;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_chunk_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_free_count    = out_count_r;

  // A zero chunk size behaves as one byte.
  assign sz_eff = (size_r == '0) ? SIZE_W'(1) : size_r;

  // Partial remainder with the next address bit shifted in.
  assign div_shift = {rem_r, addr_r[bit_cnt_r]};

  // Restart fills at most the pool depth.
  assign fill_target = (ccount_r > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : ccount_r;

  // Index of the top pool entry.
  assign count_dec = count_r - CNT_W'(1);

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = acc_r;
    alu_b   = ADDR_W'(sz_eff);
    alu_sub = 1'b0;
    case (state_r)
      S_DIV: begin
        alu_a   = ADDR_W'(div_shift);
        alu_b   = ADDR_W'(sz_eff);
        alu_sub = 1'b1;
      end
      S_ALIGN: begin
        alu_a   = addr_r;
        alu_b   = ADDR_W'(rem_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc_r;
        alu_b   = ADDR_W'(sz_eff);
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

  // Configuration writes; indexes beyond the list are ignored.
  always_comb begin
    size_nxt   = size_r;
    ccount_nxt = ccount_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHUNK_SIZE:  size_nxt   = cfg_wdata;
        REG_CHUNK_COUNT: ccount_nxt = cfg_wdata[CNT_W-1:0];
        default: begin
          size_nxt   = size_r;
          ccount_nxt = ccount_r;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    rem_nxt        = rem_r;
    bit_cnt_nxt    = bit_cnt_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    fill_n_nxt     = fill_n_r;
    count_nxt      = count_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[PTR_W-1:0];
    mem_wdata      = acc_r;
    mem_re         = 1'b0;
    mem_raddr      = count_dec[PTR_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          case (in_operation)
            OP_ALLOC: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                count_nxt = count_dec;
                state_nxt = S_READ;
              end else begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FINISH;
              end
            end
            OP_FREE: begin
              addr_nxt    = in_free_address;
              rem_nxt     = '0;
              bit_cnt_nxt = BIT_W'(ADDR_W - 1);
              state_nxt   = S_DIV;
            end
            OP_RESTART: begin
              acc_nxt    = '0;
              idx_nxt    = '0;
              fill_n_nxt = fill_target;
              if (fill_target == '0) begin
                count_nxt = '0;
                state_nxt = S_FINISH;
              end else begin
                state_nxt = S_FILL;
              end
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      // One restoring remainder step per cycle.
      S_DIV: begin
        if (!alu_res[ADDR_W]) begin
          rem_nxt = alu_res[SIZE_W-1:0];
        end else begin
          rem_nxt = div_shift[SIZE_W-1:0];
        end
        if (bit_cnt_r == '0) begin
          state_nxt = S_ALIGN;
        end else begin
          bit_cnt_nxt = bit_cnt_r - BIT_W'(1);
        end
      end
      // Aligned address is the address less its remainder; push if room.
      S_ALIGN: begin
        res_addr_nxt = alu_res[ADDR_W-1:0];
        if (count_r < CNT_W'(POOL_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = count_r[PTR_W-1:0];
          mem_wdata = alu_res[ADDR_W-1:0];
          count_nxt = count_r + CNT_W'(1);
        end else begin
          res_status_nxt = ST_FULL;
        end
        state_nxt = S_FINISH;
      end
      S_READ: begin
        res_addr_nxt = rd_data_r;
        state_nxt    = S_FINISH;
      end
      // Restart walk: entry i gets i times the chunk size.
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[PTR_W-1:0];
        mem_wdata = acc_r;
        acc_nxt   = alu_res[ADDR_W-1:0];
        idx_nxt   = idx_r + CNT_W'(1);
        if (idx_r + CNT_W'(1) == fill_n_r) begin
          count_nxt = fill_n_r;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FINISH && out_free) begin
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = res_addr_r;
      out_status_nxt = res_status_r;
      out_count_nxt  = count_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      size_r      <= SIZE_RESET;
      ccount_r    <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      ccount_r    <= ccount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    rem_r        <= rem_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    acc_r        <= acc_nxt;
    idx_r        <= idx_nxt;
    fill_n_r     <= fill_n_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Pool memory ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= pool_mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/cfla_checker.sv
// ----------------------------------------------------------------------------
// Chunk allocator checker
// Watches the ports of the chunk free-list allocator and checks its results
// and its busy behavior over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cfla_checker
  import cfla_pkg::*;
(
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input wire [ADDR_W-1:0]   out_chunk_address,
  input wire [STATUS_W-1:0] out_status,
  input wire [CNT_W-1:0]    out_free_count
);

  // Once a request is taken the block is busy on the next cycle.
  `CFLA_ASSERT_SYNC(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)

  // An empty report comes with a zero address and an empty pool.
  `CFLA_ASSERT_IMPLIES(a_empty_result, clk, rst_n, out_valid && out_status == ST_EMPTY, out_chunk_address == '0 && out_free_count == '0)

  // The reported count never exceeds the pool, and a full report means a full pool.
  `CFLA_ASSERT_IMPLIES(a_count_range, clk, rst_n, out_valid, out_free_count <= CNT_W'(POOL_DEPTH) && (out_status != ST_FULL || out_free_count == CNT_W'(POOL_DEPTH)))

  // A stalled result stays put.
  `CFLA_ASSERT_SYNC(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_chunk_address) && $stable(out_status)))

endmodule

bind chunk_free_list_allocator cfla_checker u_cfla_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_chunk_address (out_chunk_address),
  .out_status        (out_status),
  .out_free_count    (out_free_count)
);

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Chunk free-list allocator testbench
// Drives allocate, free, restart and unused requests into the allocator and
// checks every result against a shadow pool or the values a table row gives.
// A short table of hand-picked requests and register writes comes first.
// Phases of random traffic follow, each under its own chunk size and count,
// with random idle bursts on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cfla_pkg::*;

  // The request code that the block answers without changing the pool.
  localparam op_t OP_UNUSED = 2'd3;

  localparam int PHASES          = 13;
  localparam int PHASE_REQUESTS  = 100;
  localparam int LONG_HOLD_AT    = 200;
  localparam int LONG_HOLD_CYCLS = 300;

  typedef struct packed {
    addr_t   chunk_address;
    status_t status;
    count_t  free_count;
  } pool_result_t;

  // One line of the opening table: a register write or a request.
  typedef struct {
    bit           is_cfg;
    cidx_t        reg_idx;
    size_t        reg_data;
    op_t          op;
    addr_t        addr;
    bit           typed;
    pool_result_t want;
  } script_row_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  op_t     in_operation = OP_ALLOC;
  addr_t   in_free_address = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  addr_t   out_chunk_address;
  status_t out_status;
  count_t  out_free_count;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  cidx_t   cfg_index = REG_CHUNK_SIZE;
  size_t   cfg_wdata = '0;

  // Shadow of the pool and of the configuration registers.
  addr_t       pool_image [POOL_DEPTH];
  int unsigned pool_level = 0;
  size_t       cur_chunk_size = SIZE_RESET;
  count_t      cur_chunk_count = COUNT_RESET;

  pool_result_t owed_results [$];
  addr_t        handed_out [$];
  script_row_t  script [$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  bit           src_idle_on = 1'b1;
  bit           sink_idle_on = 1'b1;

  chunk_free_list_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_free_address   (in_free_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_chunk_address (out_chunk_address),
    .out_status        (out_status),
    .out_free_count    (out_free_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the shadow pool and returns the result it owes.
  function automatic pool_result_t apply_pool_request(input op_t op, input addr_t addr);
    pool_result_t     r;
    longint unsigned  unit;
    int unsigned      fill;
    r    = '0;
    unit = (cur_chunk_size == 0) ? 64'd1 : longint'(cur_chunk_size);
    case (op)
      OP_ALLOC: begin
        if (pool_level != 0) begin
          pool_level--;
          r.chunk_address = pool_image[pool_level];
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_FREE: begin
        // Round down to the start of the chunk.
        r.chunk_address = addr_t'(longint'(addr) - longint'(addr) % unit);
        if (pool_level < POOL_DEPTH) begin
          pool_image[pool_level] = r.chunk_address;
          pool_level++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_RESTART: begin
        // Refill with consecutive chunks; addresses wrap at the address width.
        fill = (cur_chunk_count > POOL_DEPTH) ? POOL_DEPTH : cur_chunk_count;
        for (int i = 0; i < fill; i++)
          pool_image[i] = addr_t'(longint'(i) * unit);
        pool_level = fill;
      end
      default: begin
      end
    endcase
    r.free_count = count_t'(pool_level);
    return r;
  endfunction

  function automatic script_row_t row_req(input op_t op, input addr_t addr);
    script_row_t row;
    row        = '{default: '0};
    row.op     = op;
    row.addr   = addr;
    return row;
  endfunction

  function automatic script_row_t row_chk(input op_t op, input addr_t addr,
                                          input addr_t ea, input status_t es,
                                          input count_t ec);
    script_row_t row;
    row       = row_req(op, addr);
    row.typed = 1'b1;
    row.want  = '{chunk_address: ea, status: es, free_count: ec};
    return row;
  endfunction

  function automatic script_row_t row_cfg(input cidx_t idx, input size_t data);
    script_row_t row;
    row          = '{default: '0};
    row.is_cfg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  // Offers one request, waits for it to be taken and records what it owes.
  task automatic send_request(input op_t op, input addr_t addr, input bit typed,
                              input pool_result_t typed_want);
    pool_result_t model;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_free_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = apply_pool_request(op, addr);
    owed_results.push_back(typed ? typed_want : model);
    if (op == OP_ALLOC && model.status == ST_OK)
      handed_out.push_back(model.chunk_address);
    if (op == OP_RESTART)
      handed_out.delete();
  endtask

  task automatic wait_drained();
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Writes one register; cfg_valid stays high when another write follows.
  task automatic write_reg(input cidx_t idx, input size_t data, input bit lower);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CHUNK_SIZE)
      cur_chunk_size = data;
    else if (idx == REG_CHUNK_COUNT)
      cur_chunk_count = data[CNT_W-1:0];
    if (lower)
      cfg_valid <= 1'b0;
  endtask

  // Result side: checks each accepted result and paces out_stall.
  initial begin : result_side
    pool_result_t want;
    int unsigned  stall_left;
    bit           long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("result with nothing pending: address %h status %0d count %0d",
                 out_chunk_address, out_status, out_free_count);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_chunk_address !== want.chunk_address) begin
            $error("chunk_address: expected %h, actual %h", want.chunk_address,
                   out_chunk_address);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_free_count !== want.free_count) begin
            $error("free_count: expected %0d, actual %0d", want.free_count,
                   out_free_count);
            mismatches++;
          end
        end
      end
      // One long hold-off so that the request side backs up.
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLS;
      end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Request side: opening table, random phases, then the final report.
  initial begin : request_side
    size_t       size_val;
    count_t      count_val;
    int unsigned alloc_pct;
    int unsigned roll;
    int unsigned pick;
    int unsigned unit;
    int unsigned waited;
    op_t         op;
    addr_t       addr;
    bit          lower;

    // Hand-picked requests under the reset configuration and its extremes.
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, '0, ST_EMPTY, 13'd0));
    script.push_back(row_chk(OP_FREE, 28'hFFFFFFF, 28'hFFFF800, ST_OK, 13'd1));
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, 28'hFFFF800, ST_OK, 13'd0));
    script.push_back(row_chk(OP_UNUSED, 28'h0ABCDEF, '0, ST_OK, 13'd0));
    script.push_back(row_chk(OP_RESTART, 28'h0000000, '0, ST_OK, 13'd4096));
    script.push_back(row_chk(OP_FREE, 28'd12345, 28'd12288, ST_FULL, 13'd4096));
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, 28'h07FF800, ST_OK, 13'd4095));
    script.push_back(row_req(OP_FREE, 28'h07FF801));
    // A zero chunk size behaves as one byte.
    script.push_back(row_cfg(REG_CHUNK_SIZE, 17'd0));
    script.push_back(row_chk(OP_FREE, 28'hFFFFFFF, 28'hFFFFFFF, ST_FULL, 13'd4096));
    script.push_back(row_chk(OP_RESTART, 28'h0000000, '0, ST_OK, 13'd4096));
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, 28'd4095, ST_OK, 13'd4095));
    // Widest size wraps the restart addresses; an oversized count saturates.
    script.push_back(row_cfg(REG_CHUNK_SIZE, 17'h1FFFF));
    script.push_back(row_cfg(REG_CHUNK_COUNT, 17'd8191));
    script.push_back(row_chk(OP_RESTART, 28'h0000000, '0, ST_OK, 13'd4096));
    script.push_back(row_req(OP_ALLOC, 28'h0000000));
    script.push_back(row_req(OP_FREE, 28'hFFFFFFF));
    // A zero count leaves the pool empty.
    script.push_back(row_cfg(REG_CHUNK_COUNT, 17'd0));
    script.push_back(row_chk(OP_RESTART, 28'h0000000, '0, ST_OK, 13'd0));
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, '0, ST_EMPTY, 13'd0));
    script.push_back(row_cfg(REG_CHUNK_SIZE, 17'd1));
    script.push_back(row_cfg(REG_CHUNK_COUNT, 17'd1));
    script.push_back(row_chk(OP_RESTART, 28'h0000000, '0, ST_OK, 13'd1));
    script.push_back(row_chk(OP_FREE, 28'h0000003, 28'h0000003, ST_OK, 13'd2));
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, 28'h0000003, ST_OK, 13'd1));
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, 28'h0000000, ST_OK, 13'd0));
    script.push_back(row_chk(OP_ALLOC, 28'h0000000, '0, ST_EMPTY, 13'd0));
    // A size that is not a power of two.
    script.push_back(row_cfg(REG_CHUNK_SIZE, 17'd3));
    script.push_back(row_cfg(REG_CHUNK_COUNT, 17'd4096));
    script.push_back(row_req(OP_FREE, 28'h0000008));
    script.push_back(row_req(OP_FREE, 28'hAAAAAAA));
    script.push_back(row_req(OP_UNUSED, 28'hFFFFFFF));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].is_cfg) begin
        in_valid <= 1'b0;
        wait_drained();
        lower = !(r + 1 < script.size() && script[r + 1].is_cfg);
        write_reg(script[r].reg_idx, script[r].reg_data, lower);
      end else begin
        send_request(script[r].op, script[r].addr, script[r].typed, script[r].want);
      end
    end

    // Random phases, each under a fresh configuration written while idle.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       size_val = 17'd0;
        1:       size_val = 17'd1;
        2:       size_val = size_t'(1 << $urandom_range(0, 16));
        3:       size_val = 17'h1FFFF;
        default: size_val = size_t'($urandom_range(1, 65536));
      endcase
      case ($urandom_range(0, 7))
        0:       count_val = 13'd0;
        1:       count_val = count_t'($urandom_range(4096, 8191));
        default: count_val = count_t'($urandom_range(1, 48));
      endcase
      if (p == 1)
        count_val = 13'd4096;
      unit = (size_val == 0) ? 1 : size_val;

      in_valid <= 1'b0;
      wait_drained();
      write_reg(REG_CHUNK_SIZE, size_val, 1'b0);
      write_reg(REG_CHUNK_COUNT, size_t'(count_val), 1'b1);

      // The closing phases run without idle cycles on either side.
      src_idle_on  = (p % 4 != 3) && (p < PHASES - 2);
      sink_idle_on = (p % 3 != 1) && (p < PHASES - 2);
      alloc_pct    = $urandom_range(25, 60);

      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        roll = $urandom_range(0, 99);
        if (k == 0 && $urandom_range(0, 4) != 0)
          op = OP_RESTART;
        else if (roll < 4)
          op = OP_RESTART;
        else if (roll < 6)
          op = OP_UNUSED;
        else if (roll < 6 + alloc_pct)
          op = OP_ALLOC;
        else
          op = OP_FREE;
        addr = addr_t'($urandom());
        // Mostly return a chunk that was handed out, at any offset inside it.
        if (op == OP_FREE && handed_out.size() != 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, handed_out.size() - 1);
          addr = handed_out[pick] + addr_t'($urandom_range(0, unit - 1));
          handed_out.delete(pick);
        end
        send_request(op, addr, 1'b0, '0);
      end
    end

    // Let the last results come out, then allow time for any stray one.
    in_valid <= 1'b0;
    waited = 0;
    while (owed_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("chunk_free_list_allocator: match");
    else
      $display("chunk_free_list_allocator: mismatch");
    $finish;
  end

  // Run time guard.
  initial begin : run_guard
    #10000000;
    $display("chunk_free_list_allocator: mismatch");
    $finish;
  end

endmodule
